/* hdl/rlfs_pkg.sv */
// Shared codes, widths, the hue table and the control/status bundles of the LED fade sequencer.
`default_nettype none

package rlfs_pkg;

    // command codes carried in s_tuser
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_COLOR   = 3'd1;
    localparam logic [2:0] OP_FADE    = 3'd2;
    localparam logic [2:0] OP_GLOW    = 3'd3;
    localparam logic [2:0] OP_RAINBOW = 3'd4;

    // effect phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_FADE     = 3'd1;
    localparam logic [2:0] PH_HOLD     = 3'd2;
    localparam logic [2:0] PH_FADE_OUT = 3'd3;
    localparam logic [2:0] PH_GAP      = 3'd4;

    // effect kinds
    localparam logic [1:0] FX_NONE    = 2'd0;
    localparam logic [1:0] FX_FADE    = 2'd1;
    localparam logic [1:0] FX_GLOW    = 2'd2;
    localparam logic [1:0] FX_RAINBOW = 2'd3;

    // configuration register indexes
    localparam logic CFG_STEP_PERIOD = 1'b0;
    localparam logic CFG_GLOW_GAP    = 1'b1;

    localparam logic [7:0]  STEP_PERIOD_RESET = 8'd20;
    localparam logic [15:0] GLOW_GAP_RESET    = 16'd50;

    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 32;
    localparam int OP_W       = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [2:0] HUE_LAST = 3'd5;

    // rainbow hue: bit 0 red, bit 1 green, bit 2 blue at full scale
    function automatic logic [2:0] hue_mask(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0:    m = 3'b011;
            3'd1:    m = 3'b001;
            3'd2:    m = 3'b101;
            3'd3:    m = 3'b100;
            3'd4:    m = 3'b110;
            3'd5:    m = 3'b010;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    typedef struct packed {
        logic       latch;
        logic       tick_dec;
        logic       step_inc;
        logic       show_target;
        logic       set_color;
        logic       reject;
        logic       save_params;
        logic       load_rounds;
        logic       set_effect;
        logic [1:0] effect;
        logic       set_phase;
        logic [2:0] phase;
        logic       cand_item;
        logic       cand_black;
        logic       cand_hue;
        logic       rb_next;
        logic       load_fade;
        logic       div_go;
        logic       div_sel_total;
        logic       load_total;
        logic       mul_go;
        logic [1:0] chan;
        logic       write_chan;
        logic       ms_period;
        logic       ms_hold;
        logic       ms_gap;
        logic       ms_clear;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic [2:0] phase;
        logic [1:0] effect;
        logic       ms_expire;
        logic       more_steps;
        logic       total_short;
        logic       hold_zero;
        logic       gap_zero;
        logic       cycles_zero;
        logic       rb_end;
        logic       div_done;
    } status_t;

endpackage

`default_nettype wire

/* hdl/rgb_led_fade_sequencer_core.sv */
// Top level of the RGB LED fade sequencer: stream ports, configuration port, controller and datapath.
//
// One result transfer leaves for every command transfer taken. Each command is handled
// on its own: a tick that only counts down, a set-colour, a rejected or unused command
// goes from decode straight to the result. Every fade step shown recomputes three channels
// through one shared restoring divider that yields one quotient bit a cycle, and starting
// a fade runs the divider once more to work out the step count. Segments that take no
// time (fades shorter than two steps, zero holds and gaps) chain inside one command,
// paying the fade start cost for each, so a rainbow of many instant rounds can hold the
// input off for a long time. Configuration writes are always taken and must be made while idle.
`default_nettype none

module rgb_led_fade_sequencer_core #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic                            cfg_index,
    input  wire logic [rlfs_pkg::CFG_DATA_W-1:0] cfg_data,
    // command stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // red[7:0], green[15:8], blue[23:16], duration_ms[39:24], hold_ms[55:40],
    // cycle_count[71:56]
    input  wire logic [rlfs_pkg::S_TDATA_W-1:0]  s_tdata,
    // opcode[2:0]
    input  wire logic [rlfs_pkg::OP_W-1:0]       s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // red_drive[7:0], green_drive[15:8], blue_drive[23:16], busy_res[24],
    // rejected[25], zero[31:26]
    output logic [rlfs_pkg::M_TDATA_W-1:0]       m_tdata
);

    rlfs_pkg::cmd_t    cmd;
    rlfs_pkg::status_t status;

    assign cfg_ready = 1'b1;

    rlfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rlfs_datapath #(
        .COLOR_BITS (COLOR_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

/* hdl/rlfs_div.sv */
// Restoring unsigned divider, one quotient bit per clock.
`default_nettype none

module rlfs_div #(
    parameter int DW = 24,
    parameter int VW = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output logic               done,
    output logic [DW-1:0]      quotient
);

    localparam int CW = $clog2(DW + 1);

    logic          running_reg;
    logic          done_reg;
    logic [CW-1:0] count_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;

    logic [VW:0]   shifted;
    logic [VW:0]   diff;
    logic          ge;
    logic [VW-1:0] rem_next;
    logic [DW-1:0] quo_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, divisor};
        ge       = ~diff[VW];
        rem_next = ge ? diff[VW-1:0] : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            count_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                running_reg <= 1'b1;
                count_reg   <= CW'(DW);
            end else if (running_reg) begin
                count_reg <= count_reg - CW'(1);
                if (count_reg == CW'(1)) begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (running_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* hdl/rlfs_datapath.sv */
// Effect state, colour registers, step arithmetic and result register of the fade sequencer.
`default_nettype none

module rlfs_datapath #(
    parameter int COLOR_BITS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [rlfs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic [rlfs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [rlfs_pkg::OP_W-1:0]         s_tuser,
    input  wire rlfs_pkg::cmd_t                    cmd,
    output rlfs_pkg::status_t                      status,
    output logic [rlfs_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int CB = COLOR_BITS;
    localparam int PW = COLOR_BITS + 16;
    localparam int M_TDATA_W_L = rlfs_pkg::M_TDATA_W;

    // configuration
    logic [7:0]  cfg_period_reg;
    logic [15:0] cfg_gap_reg;
    logic [7:0]  period;

    // latched input item
    logic [2:0]    item_op_reg;
    logic [CB-1:0] item_color_reg [3];
    logic [15:0]   item_dur_reg;
    logic [15:0]   item_hold_reg;
    logic [15:0]   item_cycles_reg;

    // effect state
    logic [CB-1:0] shown_reg  [3];
    logic [CB-1:0] start_reg  [3];
    logic [CB-1:0] target_reg [3];
    logic [CB-1:0] cand_reg   [3];
    logic [15:0]   step_index_reg;
    logic [15:0]   step_total_reg;
    logic [15:0]   ms_left_reg;
    logic [2:0]    phase_reg;
    logic [1:0]    effect_reg;
    logic [2:0]    rb_idx_reg;
    logic [15:0]   rounds_reg;
    logic [15:0]   saved_dur_reg;
    logic [15:0]   saved_hold_reg;
    logic          rej_reg;

    // step arithmetic
    logic [PW-1:0] prod_reg;
    logic          neg_reg;
    logic [CB-1:0] mag;
    logic          mag_neg;
    logic [PW-1:0] div_dividend;
    logic [15:0]   div_divisor;
    logic          div_done;
    logic [PW-1:0] div_quo;
    logic [CB-1:0] step_value;

    // rainbow advance
    logic          rb_wrap;
    logic [2:0]    rb_idx_next;
    logic [15:0]   rounds_next;
    logic [2:0]    hue;

    logic [CB+7:0] in_ext  [3];
    logic [CB+7:0] out_ext [3];
    logic [7:0]    drive   [3];
    logic [M_TDATA_W_L-1:0] out_word;
    logic [M_TDATA_W_L-1:0] m_tdata_reg;

    assign period = (cfg_period_reg == 8'd0) ? 8'd1 : cfg_period_reg;

    always_comb begin
        in_ext[0] = {{CB{1'b0}}, s_tdata[7:0]};
        in_ext[1] = {{CB{1'b0}}, s_tdata[15:8]};
        in_ext[2] = {{CB{1'b0}}, s_tdata[23:16]};
        for (int c = 0; c < 3; c++) begin
            out_ext[c] = {8'd0, ~shown_reg[c]};
            drive[c]   = out_ext[c][7:0];
        end
        out_word = {6'd0, rej_reg, (phase_reg != rlfs_pkg::PH_IDLE),
                    drive[2], drive[1], drive[0]};
    end

    always_comb begin
        mag_neg = target_reg[cmd.chan] < start_reg[cmd.chan];
        mag     = mag_neg ? (start_reg[cmd.chan] - target_reg[cmd.chan])
                          : (target_reg[cmd.chan] - start_reg[cmd.chan]);
        step_value = neg_reg ? (start_reg[cmd.chan] - div_quo[CB-1:0])
                             : (start_reg[cmd.chan] + div_quo[CB-1:0]);
        div_dividend = cmd.div_sel_total ? PW'(saved_dur_reg) : prod_reg;
        div_divisor  = cmd.div_sel_total ? {8'd0, period} : step_total_reg;
    end

    always_comb begin
        rb_wrap     = (rb_idx_reg == rlfs_pkg::HUE_LAST);
        rb_idx_next = rb_wrap ? 3'd0 : rb_idx_reg + 3'd1;
        rounds_next = (rb_wrap && rounds_reg != 16'd0) ? rounds_reg - 16'd1 : rounds_reg;
        hue         = rlfs_pkg::hue_mask(rb_idx_reg);
    end

    rlfs_div #(
        .DW (PW),
        .VW (16)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_go),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_period_reg <= rlfs_pkg::STEP_PERIOD_RESET;
            cfg_gap_reg    <= rlfs_pkg::GLOW_GAP_RESET;
            for (int c = 0; c < 3; c++) begin
                shown_reg[c]  <= '0;
                start_reg[c]  <= '0;
                target_reg[c] <= '0;
            end
            step_index_reg <= '0;
            step_total_reg <= '0;
            ms_left_reg    <= '0;
            phase_reg      <= rlfs_pkg::PH_IDLE;
            effect_reg     <= rlfs_pkg::FX_NONE;
            rb_idx_reg     <= '0;
            rounds_reg     <= '0;
            saved_dur_reg  <= '0;
            saved_hold_reg <= '0;
            rej_reg        <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    rlfs_pkg::CFG_STEP_PERIOD: cfg_period_reg <= cfg_data[7:0];
                    rlfs_pkg::CFG_GLOW_GAP:    cfg_gap_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.latch)
                rej_reg <= 1'b0;
            if (cmd.reject)
                rej_reg <= 1'b1;
            if (cmd.tick_dec && ms_left_reg != 16'd0)
                ms_left_reg <= ms_left_reg - 16'd1;
            if (cmd.step_inc)
                step_index_reg <= step_index_reg + 16'd1;
            if (cmd.show_target) begin
                for (int c = 0; c < 3; c++)
                    shown_reg[c] <= target_reg[c];
            end
            if (cmd.set_color) begin
                for (int c = 0; c < 3; c++)
                    shown_reg[c] <= item_color_reg[c];
            end
            if (cmd.save_params) begin
                saved_dur_reg  <= item_dur_reg;
                saved_hold_reg <= item_hold_reg;
            end
            if (cmd.load_rounds) begin
                rounds_reg <= item_cycles_reg;
                rb_idx_reg <= 3'd0;
            end
            if (cmd.rb_next) begin
                rounds_reg <= rounds_next;
                rb_idx_reg <= rb_idx_next;
            end
            if (cmd.set_effect)
                effect_reg <= cmd.effect;
            if (cmd.set_phase)
                phase_reg <= cmd.phase;
            // snapshot the shown colour as the fade origin
            if (cmd.load_fade) begin
                for (int c = 0; c < 3; c++) begin
                    start_reg[c]  <= shown_reg[c];
                    target_reg[c] <= cand_reg[c];
                end
            end
            if (cmd.load_total) begin
                step_total_reg <= div_quo[15:0];
                step_index_reg <= 16'd0;
            end
            if (cmd.write_chan)
                shown_reg[cmd.chan] <= step_value;
            if (cmd.ms_period)
                ms_left_reg <= {8'd0, period};
            if (cmd.ms_hold)
                ms_left_reg <= saved_hold_reg;
            if (cmd.ms_gap)
                ms_left_reg <= cfg_gap_reg;
            if (cmd.ms_clear)
                ms_left_reg <= 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            item_op_reg       <= s_tuser;
            item_color_reg[0] <= in_ext[0][CB-1:0];
            item_color_reg[1] <= in_ext[1][CB-1:0];
            item_color_reg[2] <= in_ext[2][CB-1:0];
            item_dur_reg      <= s_tdata[39:24];
            item_hold_reg     <= s_tdata[55:40];
            item_cycles_reg   <= s_tdata[71:56];
        end
        if (cmd.cand_item) begin
            for (int c = 0; c < 3; c++)
                cand_reg[c] <= item_color_reg[c];
        end
        if (cmd.cand_black) begin
            for (int c = 0; c < 3; c++)
                cand_reg[c] <= '0;
        end
        if (cmd.cand_hue) begin
            for (int c = 0; c < 3; c++)
                cand_reg[c] <= {CB{hue[c]}};
        end
        if (cmd.mul_go) begin
            prod_reg <= PW'(mag) * PW'(step_index_reg);
            neg_reg  <= mag_neg;
        end
        if (cmd.emit)
            m_tdata_reg <= out_word;
    end

    always_comb begin
        status.op          = item_op_reg;
        status.phase       = phase_reg;
        status.effect      = effect_reg;
        status.ms_expire   = (ms_left_reg < 16'd2);
        status.more_steps  = ({1'b0, step_index_reg} + 17'd1) < {1'b0, step_total_reg};
        status.total_short = (step_total_reg < 16'd2);
        status.hold_zero   = (saved_hold_reg == 16'd0);
        status.gap_zero    = (cfg_gap_reg == 16'd0);
        status.cycles_zero = (item_cycles_reg == 16'd0);
        status.rb_end      = (rounds_next == 16'd0);
        status.div_done    = div_done;
    end

    assign m_tdata = m_tdata_reg;

endmodule

`default_nettype wire

/* hdl/rlfs_ctrl.sv */
// Sequencing state machine: decodes each command, walks fade and effect segments, issues datapath commands.
`default_nettype none

module rlfs_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    input  wire rlfs_pkg::status_t status,
    output rlfs_pkg::cmd_t         cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DECODE     = 4'd1;
    localparam logic [3:0] S_STEP_CHK   = 4'd2;
    localparam logic [3:0] S_FADE       = 4'd3;
    localparam logic [3:0] S_TOTAL_WAIT = 4'd4;
    localparam logic [3:0] S_TOTAL_CHK  = 4'd5;
    localparam logic [3:0] S_MUL        = 4'd6;
    localparam logic [3:0] S_DIV_GO     = 4'd7;
    localparam logic [3:0] S_DIV_WAIT   = 4'd8;
    localparam logic [3:0] S_ADV        = 4'd9;
    localparam logic [3:0] S_RB_HUE     = 4'd10;
    localparam logic [3:0] S_EMIT       = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] chan_reg, chan_next;
    logic       m_tvalid_reg;
    logic       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd        = '0;
        cmd.chan   = chan_reg;
        state_next = state_reg;
        chan_next  = chan_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_EMIT;
                case (status.op)
                    rlfs_pkg::OP_TICK: begin
                        if (status.phase != rlfs_pkg::PH_IDLE) begin
                            cmd.tick_dec = 1'b1;
                            if (status.ms_expire) begin
                                if (status.phase == rlfs_pkg::PH_FADE ||
                                    status.phase == rlfs_pkg::PH_FADE_OUT) begin
                                    cmd.step_inc = 1'b1;
                                    state_next   = S_STEP_CHK;
                                end else begin
                                    state_next = S_ADV;
                                end
                            end
                        end
                    end
                    rlfs_pkg::OP_COLOR, rlfs_pkg::OP_FADE, rlfs_pkg::OP_GLOW,
                    rlfs_pkg::OP_RAINBOW: begin
                        if (status.phase != rlfs_pkg::PH_IDLE) begin
                            cmd.reject = 1'b1;
                        end else if (status.op == rlfs_pkg::OP_COLOR) begin
                            cmd.set_color = 1'b1;
                        end else if (status.op == rlfs_pkg::OP_RAINBOW) begin
                            cmd.save_params = 1'b1;
                            cmd.load_rounds = 1'b1;
                            if (!status.cycles_zero) begin
                                cmd.set_effect = 1'b1;
                                cmd.effect     = rlfs_pkg::FX_RAINBOW;
                                cmd.set_phase  = 1'b1;
                                cmd.phase      = rlfs_pkg::PH_FADE;
                                state_next     = S_RB_HUE;
                            end
                        end else begin
                            cmd.save_params = 1'b1;
                            cmd.set_effect  = 1'b1;
                            cmd.effect      = (status.op == rlfs_pkg::OP_GLOW) ?
                                              rlfs_pkg::FX_GLOW : rlfs_pkg::FX_FADE;
                            cmd.set_phase   = 1'b1;
                            cmd.phase       = rlfs_pkg::PH_FADE;
                            cmd.cand_item   = 1'b1;
                            state_next      = S_FADE;
                        end
                    end
                    default: ;
                endcase
            end
            S_STEP_CHK: begin
                if (status.more_steps) begin
                    chan_next  = 2'd0;
                    state_next = S_MUL;
                end else begin
                    cmd.show_target = 1'b1;
                    state_next      = S_ADV;
                end
            end
            S_FADE: begin
                cmd.load_fade     = 1'b1;
                cmd.div_go        = 1'b1;
                cmd.div_sel_total = 1'b1;
                state_next        = S_TOTAL_WAIT;
            end
            S_TOTAL_WAIT: begin
                cmd.div_sel_total = 1'b1;
                if (status.div_done) begin
                    cmd.load_total = 1'b1;
                    state_next     = S_TOTAL_CHK;
                end
            end
            S_TOTAL_CHK: begin
                // fewer than two steps: jump straight to the target
                if (status.total_short) begin
                    cmd.show_target = 1'b1;
                    state_next      = S_ADV;
                end else begin
                    chan_next  = 2'd0;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                cmd.mul_go = 1'b1;
                state_next = S_DIV_GO;
            end
            S_DIV_GO: begin
                cmd.div_go = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.write_chan = 1'b1;
                    if (chan_reg == 2'd2) begin
                        cmd.ms_period = 1'b1;
                        state_next    = S_EMIT;
                    end else begin
                        chan_next  = chan_reg + 2'd1;
                        state_next = S_MUL;
                    end
                end
            end
            S_ADV: begin
                state_next = S_EMIT;
                if ((status.effect == rlfs_pkg::FX_GLOW ||
                     status.effect == rlfs_pkg::FX_RAINBOW) &&
                    status.phase == rlfs_pkg::PH_FADE) begin
                    cmd.set_phase = 1'b1;
                    cmd.phase     = rlfs_pkg::PH_HOLD;
                    cmd.ms_hold   = 1'b1;
                    if (status.hold_zero)
                        state_next = S_ADV;
                end else if (status.effect == rlfs_pkg::FX_GLOW &&
                             status.phase == rlfs_pkg::PH_HOLD) begin
                    cmd.set_phase  = 1'b1;
                    cmd.phase      = rlfs_pkg::PH_FADE_OUT;
                    cmd.cand_black = 1'b1;
                    state_next     = S_FADE;
                end else if (status.effect == rlfs_pkg::FX_GLOW &&
                             status.phase == rlfs_pkg::PH_FADE_OUT) begin
                    cmd.set_phase = 1'b1;
                    cmd.phase     = rlfs_pkg::PH_GAP;
                    cmd.ms_gap    = 1'b1;
                    if (status.gap_zero)
                        state_next = S_ADV;
                end else if (status.effect == rlfs_pkg::FX_RAINBOW && !status.rb_end) begin
                    cmd.rb_next   = 1'b1;
                    cmd.set_phase = 1'b1;
                    cmd.phase     = rlfs_pkg::PH_FADE;
                    state_next    = S_RB_HUE;
                end else begin
                    cmd.rb_next    = (status.effect == rlfs_pkg::FX_RAINBOW);
                    cmd.set_phase  = 1'b1;
                    cmd.phase      = rlfs_pkg::PH_IDLE;
                    cmd.set_effect = 1'b1;
                    cmd.effect     = rlfs_pkg::FX_NONE;
                    cmd.ms_clear   = 1'b1;
                end
            end
            S_RB_HUE: begin
                cmd.cand_hue = 1'b1;
                state_next   = S_FADE;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            chan_reg     <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            chan_reg  <= chan_next;
            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
